### sv/spiral_index_to_coordinate_defines.svh
// Assertion macros shared by the spiral index to coordinate RTL.
// Standalone header; the asserting module takes it in with an include.
`ifndef SPIRAL_INDEX_TO_COORDINATE_DEFINES_SVH
`define SPIRAL_INDEX_TO_COORDINATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPX_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPX_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/spidx_pkg.sv
// Package for the spiral index to coordinate block: field widths,
// register map constants and the pipeline stage record. No dependencies.
package spidx_pkg;

    localparam int IDX_W   = 16;          // cell index width
    localparam int COORD_W = 8;           // row and column width
    localparam int RING_W  = 7;           // ring count, at most 127 for a 16-bit index
    localparam int N_W     = RING_W + 2;  // grid side width, also holds twice the ring count
    localparam int SQ_W    = 2 * N_W;     // width of the side squared

    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;

    // Register indexes, taken from the word address bit of paddr.
    localparam logic REG_GRID_SIZE = 1'b0;

    localparam logic [N_W-1:0] GRID_SIZE_RST = N_W'(1);

    // Record carried through the ring search stages.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [N_W-1:0]    n;
        logic [RING_W-1:0] k;
        logic [IDX_W-1:0]  fk;
        logic              err;
    } t_srch;

    // Record after the ring search: offset within the ring and ring side.
    typedef struct packed {
        logic [IDX_W-1:0]  rem;
        logic [N_W-1:0]    m;
        logic [RING_W-1:0] k;
        logic              err;
    } t_edge;

endpackage

### sv/spiral_index_to_coordinate.sv
// Top level of the spiral index to coordinate block: register port and pipeline.
// Depends on spidx_pkg and spiral_index_to_coordinate_defines.svh.
//
//  Channel   | Direction | Handshake            | Payload
//  ----------+-----------+----------------------+------------------------------------
//  input     | in        | i_valid / o_stall    | i_cell_index
//  result    | out       | o_valid / i_stall    | o_row, o_col, o_index_error
//  register  | in        | psel/penable/pwrite  | paddr, pwdata, prdata (pready high)
//
// One transaction enters per cycle unless the result channel stalls.
// The pipeline depth is set by the ring search: one stage per bit of the ring number.
// Reset clears the valid bits and sets grid_size to one; there is no clearing pass.
// A stall on the result channel freezes the whole pipeline, so nothing is lost or repeated,
// and o_stall rises in the same cycle that a held result is stalled.
//
// How it works. Removing k whole rings of a grid of side n takes away 4k(n-k) cells.
// That count grows with k while 2k <= n, so the ring that holds an index is the largest
// k with 2k <= n and 4k(n-k) <= index. The search finds k one bit per stage, from the
// top bit down, with one small multiplier per stage. The next stage forms the offset
// within that ring and the ring side n-2k, and the last stage picks the top, right,
// bottom or left edge. A ring side of one is the center cell of an odd grid.
module spiral_index_to_coordinate #(
    parameter int MAX_SIZE = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [spidx_pkg::IDX_W-1:0]         i_cell_index,

    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [spidx_pkg::COORD_W-1:0]       o_row,
    output logic [spidx_pkg::COORD_W-1:0]       o_col,
    output logic                                o_index_error,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spidx_pkg::PADDR_W-1:0]       paddr,
    input  logic [spidx_pkg::APB_DW-1:0]        pwdata,
    output logic [spidx_pkg::APB_DW-1:0]        prdata,
    output logic                                pready
);

    `include "spiral_index_to_coordinate_defines.svh"

    localparam int IDX_W   = spidx_pkg::IDX_W;
    localparam int COORD_W = spidx_pkg::COORD_W;
    localparam int RING_W  = spidx_pkg::RING_W;
    localparam int N_W     = spidx_pkg::N_W;
    localparam int SQ_W    = spidx_pkg::SQ_W;
    localparam int APB_DW  = spidx_pkg::APB_DW;
    localparam int PW      = RING_W + N_W;      // product width of one search step
    localparam int FW      = PW + 2;            // four times that product
    localparam int CW      = IDX_W + 1;         // compare width for the edge tests
    localparam int EDGE_ST = RING_W + 1;        // stage index of the edge record

    // The side is clamped to MAX_SIZE; a register value cannot exceed its 9 bits anyway.
    localparam int            NMAX    = (MAX_SIZE < (1 << N_W) - 1) ? MAX_SIZE : (1 << N_W) - 1;
    localparam logic [N_W-1:0] N_CLAMP = N_W'(NMAX);

    // ------------------------------------------------------------------
    // Register port. The write lands at the access cycle of a transaction.
    // ------------------------------------------------------------------
    logic [N_W-1:0] r_grid_size;
    logic           w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == spidx_pkg::REG_GRID_SIZE);
    assign prdata   = (paddr[2] == spidx_pkg::REG_GRID_SIZE) ? APB_DW'(r_grid_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= spidx_pkg::GRID_SIZE_RST;
        end else if (w_cfg_wr) begin
            r_grid_size <= pwdata[N_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. All stages move together whenever the output
    // register is empty or its result is being taken.
    // ------------------------------------------------------------------
    logic w_adv;
    logic r_vld [0:EDGE_ST];
    logic r_out_vld;

    assign w_adv   = !r_out_vld || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_out_vld;

    // ------------------------------------------------------------------
    // Stage 0: clamp the side and flag an index at or beyond n squared.
    // Stages 1..RING_W: decide one bit of the ring number each.
    // ------------------------------------------------------------------
    spidx_pkg::t_srch r_s [0:RING_W];
    spidx_pkg::t_srch n_s [0:RING_W];

    logic [N_W-1:0]  w_n;
    logic [SQ_W-1:0] w_nsq;

    assign w_n   = (r_grid_size > N_CLAMP) ? N_CLAMP : r_grid_size;
    assign w_nsq = SQ_W'(w_n) * SQ_W'(w_n);

    // Tries to set bit b of the ring number: the ring must still fit in the
    // grid, and the cells of all rings outside it must not exceed the index.
    function automatic spidx_pkg::t_srch srch_step(input spidx_pkg::t_srch p,
                                                   input int unsigned b);
        spidx_pkg::t_srch  q;
        logic [RING_W-1:0] cand;
        logic [N_W-1:0]    diff;
        logic [PW-1:0]     prod;
        logic [FW-1:0]     cells;
        logic              fits;
        q          = p;
        cand       = p.k;
        cand[b]    = 1'b1;
        fits       = ({1'b0, cand, 1'b0} <= p.n);
        diff       = p.n - N_W'(cand);
        prod       = PW'(cand) * PW'(diff);
        cells      = {prod, 2'b00};
        if (fits && (cells <= FW'(p.idx))) begin
            q.k  = cand;
            q.fk = cells[IDX_W-1:0];
        end
        return q;
    endfunction

    always_comb begin
        n_s[0].idx = i_cell_index;
        n_s[0].n   = w_n;
        n_s[0].k   = '0;
        n_s[0].fk  = '0;
        n_s[0].err = (SQ_W'(i_cell_index) >= w_nsq);
        for (int s = 1; s <= RING_W; s++) begin
            n_s[s] = srch_step(r_s[s-1], RING_W - s);
        end
    end

    // ------------------------------------------------------------------
    // Edge stage input: offset within the found ring and that ring's side.
    // ------------------------------------------------------------------
    spidx_pkg::t_edge r_e;
    spidx_pkg::t_edge n_e;

    always_comb begin
        n_e.rem = r_s[RING_W].idx - r_s[RING_W].fk;
        n_e.m   = r_s[RING_W].n - {1'b0, r_s[RING_W].k, 1'b0};
        n_e.k   = r_s[RING_W].k;
        n_e.err = r_s[RING_W].err;
    end

    // ------------------------------------------------------------------
    // Output stage: place the offset on one edge of the ring. Coordinates
    // wrap at 8 bits, so the sums are formed at that width.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_out_row;
    logic [COORD_W-1:0] r_out_col;
    logic               r_out_err;
    logic [COORD_W-1:0] n_out_row;
    logic [COORD_W-1:0] n_out_col;

    always_comb begin
        logic [CW-1:0]      rem_c;
        logic [CW-1:0]      m_c;
        logic [COORD_W-1:0] rem8;
        logic [COORD_W-1:0] m8;
        logic [COORD_W-1:0] k8;
        rem_c = CW'(r_e.rem);
        m_c   = CW'(r_e.m);
        rem8  = r_e.rem[COORD_W-1:0];
        m8    = r_e.m[COORD_W-1:0];
        k8    = COORD_W'(r_e.k);
        if (r_e.err) begin
            n_out_row = '0;
            n_out_col = '0;
        end else if (r_e.m <= N_W'(1)) begin
            // Center cell of an odd grid.
            n_out_row = k8;
            n_out_col = k8;
        end else if (rem_c < m_c) begin
            // Top edge, left to right.
            n_out_row = k8;
            n_out_col = rem8 + k8;
        end else if (rem_c < {m_c[CW-2:0], 1'b0} - CW'(1)) begin
            // Right edge, top to bottom.
            n_out_row = rem8 - m8 + COORD_W'(1) + k8;
            n_out_col = m8 - COORD_W'(1) + k8;
        end else if (rem_c < {m_c[CW-2:0], 1'b0} + m_c - CW'(2)) begin
            // Bottom edge, right to left.
            n_out_row = m8 - COORD_W'(1) + k8;
            n_out_col = {m8[COORD_W-2:0], 1'b0} + m8 - COORD_W'(3) - rem8 + k8;
        end else begin
            // Left edge, bottom to top.
            n_out_row = {m8[COORD_W-3:0], 2'b00} - COORD_W'(4) - rem8 + k8;
            n_out_col = k8;
        end
    end

    // Valid bits travel with the data and are the only pipeline state that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= EDGE_ST; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s <= EDGE_ST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_vld <= r_vld[EDGE_ST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s <= RING_W; s++) begin
                r_s[s] <= n_s[s];
            end
            r_e       <= n_e;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_out_err <= r_e.err;
        end
    end

    assign o_row         = r_out_row;
    assign o_col         = r_out_col;
    assign o_index_error = r_out_err;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SPX_ASSERT_IMP(a_err_zero_coord, i_clk, i_rst_n, r_out_vld && r_out_err,
        (r_out_row == '0) && (r_out_col == '0), "out-of-range result has a nonzero coordinate")
    `SPX_ASSERT_IMP(a_ring_inside, i_clk, i_rst_n, r_vld[RING_W] && !r_s[RING_W].err,
        ({1'b0, r_s[RING_W].k, 1'b0} < r_s[RING_W].n) && (r_s[RING_W].fk <= r_s[RING_W].idx),
        "ring search ended outside the grid or past the index")
    `SPX_ASSERT_NXT(a_search_hold, i_clk, i_rst_n, !w_adv,
        (r_s[RING_W] == $past(r_s[RING_W])) && (r_e == $past(r_e)),
        "pipeline record moved while the output was stalled")
    `SPX_ASSERT_NXT(a_valid_move, i_clk, i_rst_n, w_adv,
        r_out_vld == $past(r_vld[EDGE_ST]), "valid bit lost or invented at the output stage")

endmodule
